FILE: rtl/u2rd_pkg.sv
// shared types, constants and the digit encoder for the radix digit converter
// no dependencies
`default_nettype none

package u2rd_pkg;

    // field widths
    localparam int VALUE_W = 64;
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    // default digit buffer depth
    localparam int MAX_DIGITS_DEF = 64;

    // valid radix range
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    // divider: quotient bits resolved per cycle, divider steps per digit
    localparam int BITS_PER_STEP = 4;
    localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(DIV_STEPS);

    // character constants
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
    localparam logic [RADIX_W-1:0] DEC_BASE = 6'd10;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // take a new item with a good radix
        logic err_load;   // load the error result
        logic div_step;   // one divider step
        logic store;      // write the finished remainder as a digit
        logic rd_issue;   // read the next digit from the buffer
        logic out_load;   // move buffer read data into the output register
    } u2rd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic radix_bad;  // incoming radix is out of range
        logic step_last;  // current divider step is the final one
        logic quot_zero;  // quotient after this digit is zero
        logic buf_full;   // the digit being stored fills the buffer
        logic out_last;   // the result held is the final one of the item
    } u2rd_sts_t;

    // remainder to ascii digit
    function automatic logic [CHAR_W-1:0] to_ascii(input logic [RADIX_W-1:0] rem);
        logic [CHAR_W-1:0] rem_ext;
        rem_ext = {1'b0, rem};
        if (rem < DEC_BASE)
            to_ascii = rem_ext + CHAR_ZERO;
        else
            to_ascii = rem_ext - {1'b0, DEC_BASE} + CHAR_A;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/u2rd_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module u2rd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/u2rd_dpath.sv
// datapath: shared divider, digit buffer, emit counter and output register
// depends on u2rd_pkg and u2rd_ram
`default_nettype none

module u2rd_dpath
    import u2rd_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire u2rd_cmd_t          cmd,
    output u2rd_sts_t               sts,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic [RADIX_W-1:0] radix,
    output logic      [CHAR_W-1:0]  digit_char,
    output logic                    last,
    output logic                    bad_radix
);

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    logic [VALUE_W-1:0] dividend_reg, dividend_next;
    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      emit_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;
    logic               bad_reg;
    logic [CHAR_W-1:0]  rd_data;
    logic [CW-1:0]      emit_dec;

    // restoring division, several quotient bits per cycle
    always_comb
    begin
        logic [RADIX_W-1:0] r;
        logic [VALUE_W-1:0] d;
        logic [RADIX_W:0]   t;
        r = rem_reg;
        d = dividend_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            t = {r, d[VALUE_W-1]};
            d = {d[VALUE_W-2:0], 1'b0};
            if (t >= {1'b0, radix_reg})
            begin
                r    = RADIX_W'(t - {1'b0, radix_reg});
                d[0] = 1'b1;
            end
            else
            begin
                r = RADIX_W'(t);
            end
        end
        rem_next      = r;
        dividend_next = d;
    end

    assign emit_dec = emit_reg - CW'(1);

    // status to controller
    always_comb
    begin
        sts.radix_bad = (radix < RADIX_MIN) || (radix > RADIX_MAX);
        sts.step_last = (step_reg == STEP_W'(DIV_STEPS - 1));
        sts.quot_zero = (dividend_reg == '0);
        sts.buf_full  = (count_reg == CW'(MAX_DIGITS - 1));
        sts.out_last  = last_reg;
    end

    // division registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dividend_reg <= value;
            radix_reg    <= radix;
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= dividend_next;
            rem_reg      <= rem_next;
        end
        else if (cmd.store)
        begin
            rem_reg <= '0;
        end
    end

    // step and digit counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            count_reg <= '0;
            emit_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                step_reg  <= '0;
                count_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            else if (cmd.store)
            begin
                count_reg <= count_reg + CW'(1);
                emit_reg  <= count_reg + CW'(1);
            end
            if (cmd.rd_issue)
            begin
                emit_reg <= emit_dec;
            end
        end
    end

    // digit buffer, read back most significant first
    u2rd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_DIGITS)
    ) u_buf (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (to_ascii(rem_reg)),
        .rd_en   (cmd.rd_issue),
        .rd_addr (emit_dec[AW-1:0]),
        .rd_data (rd_data)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.err_load)
        begin
            char_reg <= '0;
            last_reg <= 1'b1;
            bad_reg  <= 1'b1;
        end
        else if (cmd.out_load)
        begin
            char_reg <= rd_data;
            last_reg <= (emit_reg == '0);
            bad_reg  <= 1'b0;
        end
    end

    assign digit_char = char_reg;
    assign last       = last_reg;
    assign bad_radix  = bad_reg;

endmodule

`default_nettype wire

FILE: rtl/u2rd_ctrl.sv
// controller state machine: sequences division, storing and emission of digits
// depends on u2rd_pkg
`default_nettype none

module u2rd_ctrl
    import u2rd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire u2rd_sts_t sts,
    output u2rd_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;
    localparam logic [2:0] ST_SEND  = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_SEND);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.radix_bad)
                    begin
                        cmd.err_load = 1'b1;
                        state_next   = ST_SEND;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.step_last)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (sts.quot_zero || sts.buf_full)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_ready)
                begin
                    state_next = sts.out_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/unsigned_to_radix_digits_top.sv
// Radix digit converter: one item at a time. Each digit takes 16 steps of four quotient bits
// each in the shared divider, plus a store into the digit buffer. The stored digits are then
// emitted, each through a buffer read, an output load and a hand-off that waits for out_ready.
// A bad radix gives its single result in the cycle after acceptance.
// Reset is asynchronous, active low, clears control state; the digit buffer needs no clearing.
`default_nettype none

module unsigned_to_radix_digits_top
    import u2rd_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic [RADIX_W-1:0] radix,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [CHAR_W-1:0]  digit_char,
    output logic                    last,
    output logic                    bad_radix
);

    u2rd_cmd_t cmd;
    u2rd_sts_t sts;

    // sequencer
    u2rd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // divider, digit buffer and output register
    u2rd_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .value      (value),
        .radix      (radix),
        .digit_char (digit_char),
        .last       (last),
        .bad_radix  (bad_radix)
    );

endmodule

`default_nettype wire

FILE: rtl/u2rd_checker.sv
// port level checks for the radix digit converter, bound to the top level
// depends on u2rd_pkg and unsigned_to_radix_digits_top
`default_nettype none

module u2rd_checker
    import u2rd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic [RADIX_W-1:0] radix,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [CHAR_W-1:0]  digit_char,
    input wire logic               last,
    input wire logic               bad_radix
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last)
            && $stable(bad_radix))
        else $error("result changed while stalled");

    // one item at a time: never taking input while a result is shown
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    // an out of range radix gives its error result on the next cycle
    a_bad_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && ((radix < RADIX_MIN) || (radix > RADIX_MAX))
            |=> out_valid && bad_radix && last && (digit_char == '0))
        else $error("missing error result for bad radix");

    // good results carry a digit character
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_radix |->
            ((digit_char >= CHAR_ZERO) && (digit_char <= 7'h39))
            || ((digit_char >= CHAR_A) && (digit_char <= 7'h5A)))
        else $error("result is not a digit character");

endmodule

bind unsigned_to_radix_digits_top u2rd_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .radix      (radix),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last),
    .bad_radix  (bad_radix)
);

`default_nettype wire
